// File: hw/rtl/snt_pkg.sv
// ---------------------------------------------------------------------------
// snt_pkg: shared types and constants of the named semaphore table
// Item formats, request kinds, result codes, table sizes and the command
// and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package snt_pkg;

    // Table sizes.
    localparam int SLOTS      = 16;
    localparam int WAIT_DEPTH = 8;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QIDX_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FILL_W  = $clog2(WAIT_DEPTH + 1);
    localparam int QADDR_W = (SLOTS * WAIT_DEPTH > 1) ? $clog2(SLOTS * WAIT_DEPTH) : 1;

    // Request kinds.
    localparam logic [2:0] KIND_OPEN    = 3'd0;
    localparam logic [2:0] KIND_POST    = 3'd1;
    localparam logic [2:0] KIND_WAIT    = 3'd2;
    localparam logic [2:0] KIND_DESTROY = 3'd3;
    localparam logic [2:0] KIND_UNREG   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ERROR   = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_DEFER   = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  sem_handle;
        logic [31:0] name_key;
        logic [7:0]  initial_count;
        logic [7:0]  caller_pid;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] handle_out;
        logic [7:0] count_after;
        logic       wake_valid;
        logic [7:0] wake_pid;
    } rsp_t;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_OPEN_DONE,
        CMD_EXEC,
        CMD_QRD,
        CMD_QRD_NEXT,
        CMD_QINC,
        CMD_SHWR,
        CMD_WAKE,
        CMD_UNREG_DONE,
        CMD_FAIL,
        CMD_PUBLISH
    } cmd_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic is_open;
        logic is_post;
        logic is_unreg;
        logic bad;
        logic has_waiter;
        logic scan_last;
        logic match;
        logic q_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/named_semaphore_table.sv
// ---------------------------------------------------------------------------
// named_semaphore_table: hardware table of named counting semaphores
// Open, post, wait, destroy and unregister requests, one result per item.
// ---------------------------------------------------------------------------
// The block handles one request item at a time and returns one result item
// for each; it takes no new item until the result of the last one is on the
// output. Open scans the whole slot table one slot per cycle, also when the
// table is full. Post on a slot with waiters reads the oldest waiter from
// the queue memory and wakes it. Unregister walks the slot's wait queue
// through the queue memory, comparing each entry with the caller and moving
// the entries behind a match up by one. A new request is taken while the
// previous result still waits on the output; the one after it waits until
// that result is accepted.
`default_nettype none

module named_semaphore_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire snt_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output snt_pkg::rsp_t       rsp
);

    snt_pkg::cmd_t       cmd;
    snt_pkg::dp_status_t status;

    // Sequencer.
    snt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Slot table and wait queues.
    snt_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req_in (req),
        .rsp    (rsp),
        .status (status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/snt_dp.sv
// ---------------------------------------------------------------------------
// snt_dp: datapath of the named semaphore table
// Holds the slot table, the wait-queue memory, the request and result
// registers, and carries out one command from the controller per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module snt_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire snt_pkg::cmd_t      cmd,
    input  wire snt_pkg::req_t      req_in,
    output snt_pkg::rsp_t           rsp,
    output snt_pkg::dp_status_t     status
);

    // Slot table: control part with reset, payload part without.
    logic                          in_use_reg [snt_pkg::SLOTS];
    logic [7:0]                    refs_reg   [snt_pkg::SLOTS];
    logic [snt_pkg::QIDX_W-1:0]    head_reg   [snt_pkg::SLOTS];
    logic [snt_pkg::FILL_W-1:0]    fill_reg   [snt_pkg::SLOTS];
    logic [7:0]                    count_reg  [snt_pkg::SLOTS];
    logic [31:0]                   key_reg    [snt_pkg::SLOTS];

    // Wait-queue memory, one row of WAIT_DEPTH entries per slot.
    logic [7:0] waiter_mem [snt_pkg::SLOTS * snt_pkg::WAIT_DEPTH];

    snt_pkg::req_t                 req_reg;
    snt_pkg::rsp_t                 res_reg;
    snt_pkg::rsp_t                 rsp_reg;
    logic [snt_pkg::SLOT_W-1:0]    idx_reg;
    logic [snt_pkg::QIDX_W-1:0]    qi_reg;
    logic                          found_reg;
    logic [snt_pkg::SLOT_W-1:0]    hit_reg;
    logic [7:0]                    hit_count_reg;
    logic                          free_found_reg;
    logic [snt_pkg::SLOT_W-1:0]    free_reg;
    logic [7:0]                    rdata_reg;

    logic                          cur_in_use;
    logic [7:0]                    cur_refs;
    logic [7:0]                    cur_count;
    logic [snt_pkg::QIDX_W-1:0]    cur_head;
    logic [snt_pkg::FILL_W-1:0]    cur_fill;
    logic [snt_pkg::QIDX_W:0]      fill_ext;
    logic [snt_pkg::QIDX_W:0]      qi_ext;
    logic [snt_pkg::QIDX_W:0]      qi_inc;
    logic                          h_ok;
    logic                          bad;
    logic [7:0]                    count_inc;
    logic [7:0]                    refs_dec;
    logic                          wait_take;
    logic                          wait_full;
    logic                          destroy_free;
    logic [snt_pkg::QADDR_W-1:0]   rd_addr;
    logic [snt_pkg::QADDR_W-1:0]   wr_addr;
    logic                          wr_en;
    logic [7:0]                    wr_data;
    logic [snt_pkg::SLOT_W-1:0]    load_idx;
    logic [snt_pkg::QADDR_W-1:0]   head_pos;

    // Queue position of offset off within the queue of slot s.
    function automatic logic [snt_pkg::QADDR_W-1:0] qpos(
        input logic [snt_pkg::SLOT_W-1:0] s,
        input logic [snt_pkg::QIDX_W-1:0] head,
        input logic [snt_pkg::QIDX_W:0]   off
    );
        logic [snt_pkg::QIDX_W:0] sum;
        logic [snt_pkg::QIDX_W:0] wrapped;
        sum = {1'b0, head} + off;
        if (sum >= (snt_pkg::QIDX_W+1)'(snt_pkg::WAIT_DEPTH))
        begin
            wrapped = sum - (snt_pkg::QIDX_W+1)'(snt_pkg::WAIT_DEPTH);
        end
        else
        begin
            wrapped = sum;
        end
        return snt_pkg::QADDR_W'(s) * snt_pkg::QADDR_W'(snt_pkg::WAIT_DEPTH)
             + snt_pkg::QADDR_W'(wrapped);
    endfunction

    // The per-slot reads below all go through the single slot pointer.
    assign cur_in_use = in_use_reg[idx_reg];
    assign cur_refs   = refs_reg[idx_reg];
    assign cur_count  = count_reg[idx_reg];
    assign cur_head   = head_reg[idx_reg];
    assign cur_fill   = fill_reg[idx_reg];
    assign fill_ext   = (snt_pkg::QIDX_W+1)'(cur_fill);
    assign qi_ext     = {1'b0, qi_reg};
    assign qi_inc     = qi_ext + (snt_pkg::QIDX_W+1)'(1);

    // Head position after the oldest waiter leaves.
    assign head_pos = qpos(snt_pkg::SLOT_W'(0), cur_head, (snt_pkg::QIDX_W+1)'(1));

    // Request checks and per-kind decisions.
    assign h_ok = 32'(req_reg.sem_handle) < 32'(snt_pkg::SLOTS);
    assign bad  = (req_reg.kind > snt_pkg::KIND_UNREG) || !h_ok || !cur_in_use;

    assign count_inc    = (cur_count != 8'hFF) ? cur_count + 8'd1 : cur_count;
    assign refs_dec     = (cur_refs != 8'd0) ? cur_refs - 8'd1 : cur_refs;
    assign wait_take    = cur_count != 8'd0;
    assign wait_full    = fill_ext >= (snt_pkg::QIDX_W+1)'(snt_pkg::WAIT_DEPTH);
    assign destroy_free = (refs_dec == 8'd0) && (cur_fill == '0);

    assign load_idx = (req_in.kind == snt_pkg::KIND_OPEN) ? '0
                    : snt_pkg::SLOT_W'(req_in.sem_handle);

    // Status toward the controller.
    always_comb
    begin
        status.is_open    = req_reg.kind == snt_pkg::KIND_OPEN;
        status.is_post    = req_reg.kind == snt_pkg::KIND_POST;
        status.is_unreg   = req_reg.kind == snt_pkg::KIND_UNREG;
        status.bad        = bad;
        status.has_waiter = cur_fill != '0;
        status.scan_last  = idx_reg == snt_pkg::SLOT_W'(snt_pkg::SLOTS - 1);
        status.match      = rdata_reg == req_reg.caller_pid;
        status.q_last     = qi_inc >= fill_ext;
    end

    // Queue memory addresses and write enable.
    always_comb
    begin
        if (cmd == snt_pkg::CMD_QRD_NEXT)
        begin
            rd_addr = qpos(idx_reg, cur_head, qi_inc);
        end
        else
        begin
            rd_addr = qpos(idx_reg, cur_head, qi_ext);
        end
        wr_en   = 1'b0;
        wr_addr = qpos(idx_reg, cur_head, qi_ext);
        wr_data = rdata_reg;
        if (cmd == snt_pkg::CMD_SHWR)
        begin
            wr_en = 1'b1;
        end
        else if (cmd == snt_pkg::CMD_EXEC && req_reg.kind == snt_pkg::KIND_WAIT
                 && !wait_take && !wait_full)
        begin
            wr_en   = 1'b1;
            wr_addr = qpos(idx_reg, cur_head, fill_ext);
            wr_data = req_reg.caller_pid;
        end
    end

    // Wait-queue memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            waiter_mem[wr_addr] <= wr_data;
        end
        if (cmd == snt_pkg::CMD_QRD || cmd == snt_pkg::CMD_QRD_NEXT)
        begin
            rdata_reg <= waiter_mem[rd_addr];
        end
    end

    // Slot control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < snt_pkg::SLOTS; i++)
            begin
                in_use_reg[i] <= 1'b0;
                refs_reg[i]   <= 8'd0;
                head_reg[i]   <= '0;
                fill_reg[i]   <= '0;
            end
        end
        else
        begin
            unique case (cmd)
                snt_pkg::CMD_OPEN_DONE:
                begin
                    if (found_reg)
                    begin
                        if (refs_reg[hit_reg] != 8'hFF)
                        begin
                            refs_reg[hit_reg] <= refs_reg[hit_reg] + 8'd1;
                        end
                    end
                    else if (free_found_reg)
                    begin
                        in_use_reg[free_reg] <= 1'b1;
                        refs_reg[free_reg]   <= 8'd1;
                        head_reg[free_reg]   <= '0;
                        fill_reg[free_reg]   <= '0;
                    end
                end
                snt_pkg::CMD_EXEC:
                begin
                    if (req_reg.kind == snt_pkg::KIND_WAIT && !wait_take && !wait_full)
                    begin
                        fill_reg[idx_reg] <= cur_fill + snt_pkg::FILL_W'(1);
                    end
                    else if (req_reg.kind == snt_pkg::KIND_DESTROY)
                    begin
                        refs_reg[idx_reg] <= refs_dec;
                        if (destroy_free)
                        begin
                            in_use_reg[idx_reg] <= 1'b0;
                            head_reg[idx_reg]   <= '0;
                            fill_reg[idx_reg]   <= '0;
                        end
                    end
                end
                snt_pkg::CMD_WAKE:
                begin
                    head_reg[idx_reg] <= head_pos[snt_pkg::QIDX_W-1:0];
                    fill_reg[idx_reg] <= cur_fill - snt_pkg::FILL_W'(1);
                end
                snt_pkg::CMD_UNREG_DONE:
                begin
                    fill_reg[idx_reg] <= cur_fill - snt_pkg::FILL_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request, scan and result registers, slot payload.
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            snt_pkg::CMD_LOAD:
            begin
                req_reg        <= req_in;
                idx_reg        <= load_idx;
                qi_reg         <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            snt_pkg::CMD_SCAN:
            begin
                if (!found_reg && cur_in_use && key_reg[idx_reg] == req_reg.name_key)
                begin
                    found_reg     <= 1'b1;
                    hit_reg       <= idx_reg;
                    hit_count_reg <= cur_count;
                end
                if (!free_found_reg && !cur_in_use)
                begin
                    free_found_reg <= 1'b1;
                    free_reg       <= idx_reg;
                end
                idx_reg <= idx_reg + snt_pkg::SLOT_W'(1);
            end
            snt_pkg::CMD_OPEN_DONE:
            begin
                res_reg <= '0;
                if (found_reg)
                begin
                    res_reg.handle_out  <= 4'(hit_reg);
                    res_reg.count_after <= hit_count_reg;
                end
                else if (free_found_reg)
                begin
                    key_reg[free_reg]   <= req_reg.name_key;
                    count_reg[free_reg] <= req_reg.initial_count;
                    res_reg.handle_out  <= 4'(free_reg);
                    res_reg.count_after <= req_reg.initial_count;
                end
                else
                begin
                    res_reg.status <= snt_pkg::ST_ERROR;
                end
            end
            snt_pkg::CMD_EXEC:
            begin
                res_reg <= '0;
                unique case (req_reg.kind)
                    snt_pkg::KIND_POST:
                    begin
                        count_reg[idx_reg]  <= count_inc;
                        res_reg.count_after <= count_inc;
                    end
                    snt_pkg::KIND_WAIT:
                    begin
                        if (wait_take)
                        begin
                            count_reg[idx_reg]  <= cur_count - 8'd1;
                            res_reg.count_after <= cur_count - 8'd1;
                        end
                        else if (wait_full)
                        begin
                            res_reg.status <= snt_pkg::ST_ERROR;
                        end
                        else
                        begin
                            res_reg.status      <= snt_pkg::ST_BLOCKED;
                            res_reg.count_after <= cur_count;
                        end
                    end
                    snt_pkg::KIND_DESTROY:
                    begin
                        if (!destroy_free)
                        begin
                            res_reg.status      <= snt_pkg::ST_DEFER;
                            res_reg.count_after <= cur_count;
                        end
                    end
                    default:
                    begin
                        res_reg.status <= snt_pkg::ST_ERROR;
                    end
                endcase
            end
            snt_pkg::CMD_QINC:
            begin
                qi_reg <= qi_reg + snt_pkg::QIDX_W'(1);
            end
            snt_pkg::CMD_SHWR:
            begin
                qi_reg <= qi_reg + snt_pkg::QIDX_W'(1);
            end
            snt_pkg::CMD_WAKE:
            begin
                res_reg             <= '0;
                res_reg.count_after <= cur_count;
                res_reg.wake_valid  <= 1'b1;
                res_reg.wake_pid    <= rdata_reg;
            end
            snt_pkg::CMD_UNREG_DONE:
            begin
                res_reg             <= '0;
                res_reg.count_after <= cur_count;
            end
            snt_pkg::CMD_FAIL:
            begin
                res_reg        <= '0;
                res_reg.status <= snt_pkg::ST_ERROR;
            end
            snt_pkg::CMD_PUBLISH:
            begin
                rsp_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: hw/rtl/snt_ctrl.sv
// ---------------------------------------------------------------------------
// snt_ctrl: controller of the named semaphore table
// Sequences each request through the datapath: slot scan for open, queue
// reads for post and unregister, queue compaction, and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module snt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    input  wire snt_pkg::dp_status_t    status,
    output snt_pkg::cmd_t               cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_OPEN_END,
        S_WAKE,
        S_UREAD,
        S_UCMP,
        S_SHWR,
        S_SHCHK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;

    // Command and next state.
    always_comb
    begin
        cmd        = snt_pkg::CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = snt_pkg::CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (status.is_open)
                begin
                    state_next = S_SCAN;
                end
                else if (status.bad)
                begin
                    cmd        = snt_pkg::CMD_FAIL;
                    state_next = S_FINISH;
                end
                else if (status.is_post && status.has_waiter)
                begin
                    cmd        = snt_pkg::CMD_QRD;
                    state_next = S_WAKE;
                end
                else if (status.is_unreg && status.has_waiter)
                begin
                    cmd        = snt_pkg::CMD_QRD;
                    state_next = S_UCMP;
                end
                else
                begin
                    cmd        = snt_pkg::CMD_EXEC;
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd = snt_pkg::CMD_SCAN;
                if (status.scan_last)
                begin
                    state_next = S_OPEN_END;
                end
            end
            S_OPEN_END:
            begin
                cmd        = snt_pkg::CMD_OPEN_DONE;
                state_next = S_FINISH;
            end
            S_WAKE:
            begin
                cmd        = snt_pkg::CMD_WAKE;
                state_next = S_FINISH;
            end
            S_UREAD:
            begin
                cmd        = snt_pkg::CMD_QRD;
                state_next = S_UCMP;
            end
            S_UCMP:
            begin
                priority if (status.match && status.q_last)
                begin
                    cmd        = snt_pkg::CMD_UNREG_DONE;
                    state_next = S_FINISH;
                end
                else if (status.match)
                begin
                    cmd        = snt_pkg::CMD_QRD_NEXT;
                    state_next = S_SHWR;
                end
                else if (status.q_last)
                begin
                    cmd        = snt_pkg::CMD_FAIL;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = snt_pkg::CMD_QINC;
                    state_next = S_UREAD;
                end
            end
            S_SHWR:
            begin
                cmd        = snt_pkg::CMD_SHWR;
                state_next = S_SHCHK;
            end
            S_SHCHK:
            begin
                if (status.q_last)
                begin
                    cmd        = snt_pkg::CMD_UNREG_DONE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = snt_pkg::CMD_QRD_NEXT;
                    state_next = S_SHWR;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd        = snt_pkg::CMD_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd == snt_pkg::CMD_PUBLISH)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire
